// ----- hw/rtl/efl_pkg.sv -----
// Shared types and constants of the free list allocator.
`timescale 1ns / 1ps
package efl_pkg;

    typedef struct packed {
        logic        mode;
        logic [15:0] request_size;
        logic [15:0] block_offset;
    } t_in_item;

    typedef struct packed {
        logic [15:0] result_offset;
        logic [1:0]  status;
    } t_out_item;

    localparam logic       MODE_ALLOC = 1'b0;
    localparam logic       MODE_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OOM  = 2'd2;

    localparam logic [31:0] MIN_BLOCK        = 32'd16;
    localparam logic [31:0] FIRST_PAYLOAD    = 32'd24;
    localparam logic [31:0] PROLOGUE_PAYLOAD = 32'd8;
    localparam logic [31:0] CHUNK_RESET      = 32'd4096;
    localparam logic [15:0] CHUNK_MASK       = 16'hFFF8;

endpackage

// ----- hw/rtl/explicit_free_list_allocator_top.sv -----
// Top level: chunk register, allocator engine, heap memory, output register.
//
//  channel | dir | handshake             | payload
//  in      | in  | i_in_valid/o_in_ready | i_in_item  (mode, request_size, block_offset)
//  out     | out | o_out_valid/i_out_ready| o_out_item (result_offset, status)
//  cfg     | in  | i_cfg_we              | i_cfg_wdata (chunk_bytes)
//
// One item at a time; each step makes at most one access to the single heap memory.
// Free writes the boundary tags and coalesces. Allocate walks the free list first-fit,
// then grows, splits and coalesces as needed.
// After reset a clearing pass over the whole heap memory and the init steps
// run before the first item is taken. A result waits in the output register;
// the engine stalls only when it finishes while that register is still full.
`timescale 1ns / 1ps
module explicit_free_list_allocator_top #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  efl_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output efl_pkg::t_out_item  o_out_item
);
    import efl_pkg::*;

    localparam int AW = $clog2(HEAP_BYTES / 4);

    logic [15:0] r_chunk, w_cfg_v;
    logic        r_out_vld;
    t_out_item   r_out;
    logic        w_res_valid, w_res_ready;
    t_out_item   w_res;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [31:0]   w_wdata, w_rdata;

    assign w_cfg_v = i_cfg_wdata & CHUNK_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= CHUNK_RESET[15:0];
        end else if (i_cfg_we) begin
            r_chunk <= (w_cfg_v < MIN_BLOCK[15:0]) ? MIN_BLOCK[15:0] : w_cfg_v;
        end
    end

    assign w_res_ready = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            if (w_res_valid && w_res_ready) begin
                r_out_vld <= 1'b1;
                r_out     <= w_res;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    efl_engine #(.HEAP_BYTES(HEAP_BYTES)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_chunk     (r_chunk),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_ram_we    (w_we),
        .o_ram_waddr (w_waddr),
        .o_ram_wdata (w_wdata),
        .o_ram_raddr (w_raddr),
        .i_ram_rdata (w_rdata)
    );

    efl_ram #(.WIDTH(32), .DEPTH(HEAP_BYTES / 4)) u_heap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status == ST_DONE || o_out_item.status == ST_ZERO
                         || o_out_item.status == ST_OOM))
        else $error("bad status code");

    a_no_offset_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_DONE |-> o_out_item.result_offset == 16'd0)
        else $error("offset given with failing status");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("engine took a second item while busy");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid && !w_res_ready |=> w_res_valid && $stable(w_res))
        else $error("engine result dropped while output register full");
endmodule

// ----- hw/rtl/efl_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module efl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hw/rtl/efl_engine.sv -----
// Allocator sequencer: clear/init, first-fit walk, grow, split, free and coalesce.
`timescale 1ns / 1ps
module efl_engine #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [15:0]                         i_chunk,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  efl_pkg::t_in_item                   i_in_item,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output efl_pkg::t_out_item                  o_res,
    output logic                                o_ram_we,
    output logic [$clog2(HEAP_BYTES/4)-1:0]     o_ram_waddr,
    output logic [31:0]                         o_ram_wdata,
    output logic [$clog2(HEAP_BYTES/4)-1:0]     o_ram_raddr,
    input  logic [31:0]                         i_ram_rdata
);
    import efl_pkg::*;

    localparam int HEAP_WORDS = HEAP_BYTES / 4;
    localparam int AW         = $clog2(HEAP_WORDS);
    localparam int BRK_W      = $clog2(HEAP_BYTES) + 1;
    localparam int WALK_LIMIT = HEAP_BYTES / 16 + 1;
    localparam logic [31:0] HEAP_LIM = 32'(HEAP_BYTES);
    localparam logic [AW:0] WALK_END = (AW+1)'(WALK_LIMIT);

    typedef enum logic [5:0] {
        S_CLEAR, S_INIT0, S_INIT1, S_INIT2, S_IDLE, S_DONE, S_FR_HQ,
        S_WK_RD, S_WK_Q, S_WK_NX, S_G_START, S_G_EPI,
        S_M_START, S_M_Q1, S_M_Q2, S_M_Q3, S_M_AP, S_M_RDP, S_M_RDPQ,
        S_M_RDN, S_M_RDNQ, S_M_TAGS, S_M_PUSH, S_M_END,
        S_PB_RD, S_PB_Q, S_PB_SPLIT, S_PB_T2, S_PB_PUSH,
        S_U_RD, S_U_S, S_U_WH, S_U_P, S_U_W2,
        S_T_1, S_T_2, S_P_1, S_P_2, S_P_3
    } t_state;

    t_state     r_state, r_ret;
    logic [AW:0] r_cnt;
    logic       r_init, r_mode, r_pu, r_nu;
    logic [31:0] r_head, r_bp, r_size, r_prv, r_nxt, r_bsize, r_sa, r_sv, r_s, r_p;
    logic [BRK_W-1:0] r_brk;
    logic [16:0] r_asize;
    t_out_item  r_res;

    function automatic logic [AW-1:0] widx(input logic [31:0] a);
        return a[AW+1:2];
    endfunction

    logic [31:0] w_q, w_qsz, w_off, w_brk, w_gsum, w_grow, w_asz32, w_diff;
    logic [16:0] w_asize;
    logic        w_accept, w_free_ok;

    assign w_q     = i_ram_rdata;
    assign w_qsz   = {w_q[31:3], 3'b000};
    assign w_off   = 32'(i_in_item.block_offset);
    assign w_brk   = 32'(r_brk);
    assign w_gsum  = w_brk + r_size;
    assign w_asz32 = 32'(r_asize);
    assign w_diff  = r_bsize - w_asz32;
    assign w_grow  = (w_asz32 > 32'(i_chunk)) ? w_asz32 : 32'(i_chunk);
    assign w_asize = (i_in_item.request_size <= 16'd8) ? 17'd16 :
                     ((17'(i_in_item.request_size) + 17'd15) & ~17'd7);
    assign w_accept  = i_in_valid && (r_state == S_IDLE);
    assign w_free_ok = (w_off[2:0] == 3'd0) && (w_off >= FIRST_PAYLOAD) && (w_off < w_brk);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = '0;
        o_ram_raddr = '0;
        case (r_state)
            S_CLEAR:  begin o_ram_we = 1'b1; o_ram_waddr = r_cnt[AW-1:0]; end
            S_INIT0:  begin
                o_ram_we = 1'b1; o_ram_waddr = widx(32'd4); o_ram_wdata = MIN_BLOCK | 32'd1;
            end
            S_INIT1:  begin
                o_ram_we = 1'b1; o_ram_waddr = widx(32'd16); o_ram_wdata = MIN_BLOCK | 32'd1;
            end
            S_INIT2:  begin o_ram_we = 1'b1; o_ram_waddr = widx(32'd20); o_ram_wdata = 32'd1; end
            S_IDLE:   o_ram_raddr = widx(w_off - 32'd4);
            S_WK_RD:  o_ram_raddr = widx(r_bp - 32'd4);
            S_WK_Q:   o_ram_raddr = widx(r_bp + 32'd4);
            S_G_EPI:  begin
                o_ram_we = 1'b1; o_ram_waddr = widx(r_bp + r_size - 32'd4); o_ram_wdata = 32'd1;
            end
            S_M_START: o_ram_raddr = widx(r_bp - 32'd8);
            S_M_Q1:    o_ram_raddr = widx(r_bp - 32'd4);
            S_M_Q2:    o_ram_raddr = widx(r_bp + w_qsz - 32'd4);
            S_M_RDP:   o_ram_raddr = widx(r_prv - 32'd4);
            S_M_RDN:   o_ram_raddr = widx(r_nxt - 32'd4);
            S_PB_RD:   o_ram_raddr = widx(r_bp - 32'd4);
            S_U_RD:    o_ram_raddr = widx(r_sa + 32'd4);
            S_U_S:     o_ram_raddr = widx(r_sa);
            S_U_WH:    begin o_ram_we = 1'b1; o_ram_waddr = widx(r_s); end
            S_U_P:     begin
                o_ram_we = 1'b1; o_ram_waddr = widx(w_q + 32'd4); o_ram_wdata = r_s;
            end
            S_U_W2:    begin o_ram_we = 1'b1; o_ram_waddr = widx(r_s); o_ram_wdata = r_p; end
            S_T_1:     begin
                o_ram_we = 1'b1; o_ram_waddr = widx(r_sa - 32'd4); o_ram_wdata = r_sv;
            end
            S_T_2:     begin
                o_ram_we    = 1'b1;
                o_ram_waddr = widx(r_sa + {r_sv[31:3], 3'b000} - 32'd8);
                o_ram_wdata = r_sv;
            end
            S_P_1:     begin
                o_ram_we = 1'b1; o_ram_waddr = widx(r_sa + 32'd4); o_ram_wdata = r_head;
            end
            S_P_2:     begin o_ram_we = 1'b1; o_ram_waddr = widx(r_sa); end
            S_P_3:     begin o_ram_we = 1'b1; o_ram_waddr = widx(r_head); o_ram_wdata = r_sa; end
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ret   <= S_IDLE;
            r_cnt   <= '0;
            r_init  <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[AW-1:0] == {AW{1'b1}}) r_state <= S_INIT0;
                end
                S_INIT0: r_state <= S_INIT1;
                S_INIT1: r_state <= S_INIT2;
                S_INIT2: begin
                    r_head  <= PROLOGUE_PAYLOAD;
                    r_brk   <= BRK_W'(FIRST_PAYLOAD);
                    r_size  <= CHUNK_RESET;
                    r_init  <= 1'b1;
                    r_state <= S_G_START;
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode  <= i_in_item.mode;
                        r_res   <= '{result_offset: 16'd0,
                                     status: (i_in_item.mode == MODE_ALLOC &&
                                              i_in_item.request_size == 16'd0) ?
                                             ST_ZERO : ST_DONE};
                        r_asize <= w_asize;
                        r_bp    <= (i_in_item.mode == MODE_FREE) ? w_off : r_head;
                        r_cnt   <= '0;
                        if (i_in_item.mode == MODE_FREE) begin
                            r_state <= w_free_ok ? S_FR_HQ : S_DONE;
                        end else if (i_in_item.request_size == 16'd0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_WK_RD;
                        end
                    end
                end
                S_FR_HQ: begin
                    if (!w_q[0]) begin
                        r_state <= S_DONE;     // double free
                    end else begin
                        r_sa    <= r_bp;
                        r_sv    <= w_qsz;
                        r_ret   <= S_M_START;
                        r_state <= S_T_1;
                    end
                end
                S_WK_RD: begin
                    if (r_cnt == WALK_END) begin
                        r_size  <= w_grow;
                        r_state <= S_G_START;
                    end else begin
                        r_state <= S_WK_Q;
                    end
                end
                S_WK_Q: begin
                    if (w_q[0]) begin
                        r_size  <= w_grow;
                        r_state <= S_G_START;
                    end else if (w_qsz >= w_asz32) begin
                        r_state <= S_PB_RD;
                    end else begin
                        r_state <= S_WK_NX;
                    end
                end
                S_WK_NX: begin
                    r_bp    <= w_q;
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= S_WK_RD;
                end
                S_G_START: begin
                    if (r_size > HEAP_LIM || w_gsum > HEAP_LIM) begin
                        if (r_init) begin
                            r_init  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_res.status <= ST_OOM;
                            r_state      <= S_DONE;
                        end
                    end else begin
                        r_brk   <= w_gsum[BRK_W-1:0];
                        r_bp    <= w_brk;
                        r_sa    <= w_brk;
                        r_sv    <= r_size;
                        r_ret   <= S_G_EPI;
                        r_state <= S_T_1;
                    end
                end
                S_G_EPI:   r_state <= S_M_START;
                S_M_START: r_state <= S_M_Q1;
                S_M_Q1: begin
                    r_pu    <= w_q[0];
                    r_prv   <= r_bp - w_qsz;
                    r_state <= S_M_Q2;
                end
                S_M_Q2: begin
                    r_size  <= w_qsz;
                    r_nxt   <= r_bp + w_qsz;
                    r_state <= S_M_Q3;
                end
                S_M_Q3: begin
                    r_nu <= w_q[0];
                    if (!r_pu) begin
                        r_sa <= r_prv; r_ret <= S_M_AP; r_state <= S_U_RD;
                    end else if (!w_q[0]) begin
                        r_sa <= r_nxt; r_ret <= S_M_RDN; r_state <= S_U_RD;
                    end else begin
                        r_state <= S_M_PUSH;
                    end
                end
                S_M_AP: begin
                    if (!r_nu) begin
                        r_sa <= r_nxt; r_ret <= S_M_RDP; r_state <= S_U_RD;
                    end else begin
                        r_state <= S_M_RDP;
                    end
                end
                S_M_RDP: r_state <= S_M_RDPQ;
                S_M_RDPQ: begin
                    r_size  <= r_size + w_qsz;
                    r_bp    <= r_prv;
                    r_state <= r_nu ? S_M_TAGS : S_M_RDN;
                end
                S_M_RDN: r_state <= S_M_RDNQ;
                S_M_RDNQ: begin
                    r_size  <= r_size + w_qsz;
                    r_state <= S_M_TAGS;
                end
                S_M_TAGS: begin
                    r_sa <= r_bp; r_sv <= r_size; r_ret <= S_M_PUSH; r_state <= S_T_1;
                end
                S_M_PUSH: begin
                    r_sa <= r_bp; r_ret <= S_M_END; r_state <= S_P_1;
                end
                S_M_END: begin
                    if (r_init) begin
                        r_init  <= 1'b0;
                        r_state <= S_IDLE;
                    end else if (r_mode == MODE_ALLOC) begin
                        r_state <= S_PB_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_PB_RD: r_state <= S_PB_Q;
                S_PB_Q: begin
                    r_bsize <= w_qsz;
                    r_sa    <= r_bp;
                    r_ret   <= S_PB_SPLIT;
                    r_state <= S_U_RD;
                end
                S_PB_SPLIT: begin
                    r_res.result_offset <= r_bp[15:0];
                    r_sa <= r_bp;
                    if (r_bsize >= w_asz32 && w_diff >= MIN_BLOCK) begin
                        r_sv  <= w_asz32 | 32'd1;
                        r_ret <= S_PB_T2;
                    end else begin
                        r_sv  <= r_bsize | 32'd1;
                        r_ret <= S_DONE;
                    end
                    r_state <= S_T_1;
                end
                S_PB_T2: begin
                    r_sa <= r_bp + w_asz32; r_sv <= w_diff; r_ret <= S_PB_PUSH;
                    r_state <= S_T_1;
                end
                S_PB_PUSH: begin
                    r_sa <= r_bp + w_asz32; r_ret <= S_DONE; r_state <= S_P_1;
                end
                // unlink r_sa from the free list
                S_U_RD: r_state <= S_U_S;
                S_U_S: begin
                    r_s     <= w_q;
                    r_state <= (r_sa == r_head) ? S_U_WH : S_U_P;
                end
                S_U_WH: begin r_head <= r_s; r_state <= r_ret; end
                S_U_P:  begin r_p <= w_q; r_state <= S_U_W2; end
                S_U_W2: r_state <= r_ret;
                // boundary tags
                S_T_1: r_state <= S_T_2;
                S_T_2: r_state <= r_ret;
                // push r_sa at list head
                S_P_1: r_state <= S_P_2;
                S_P_2: r_state <= S_P_3;
                S_P_3: begin r_head <= r_sa; r_state <= r_ret; end
                S_DONE: if (i_res_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
